// File: rtl/jsu_pkg.sv
// Package for the JSON string unescaper: beat types, status and phase codes,
// character constants and small decode helpers. No dependencies.
package jsu_pkg;

    localparam int MaxRun = 4;
    localparam int RunCountW = $clog2(MaxRun + 1);

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChLf        = 8'h0A;
    localparam logic [7:0] ChCr        = 8'h0D;
    localparam logic [7:0] ChBs        = 8'h08;
    localparam logic [7:0] ChFf        = 8'h0C;
    localparam logic [7:0] ChLowB      = 8'h62;
    localparam logic [7:0] ChLowF      = 8'h66;
    localparam logic [7:0] ChLowN      = 8'h6E;
    localparam logic [7:0] ChLowR      = 8'h72;
    localparam logic [7:0] ChLowT      = 8'h74;
    localparam logic [7:0] ChLowU      = 8'h75;

    localparam logic [7:0] Utf8Cont  = 8'h80;
    localparam logic [7:0] Utf8Lead2 = 8'hC0;
    localparam logic [7:0] Utf8Lead3 = 8'hE0;

    typedef enum logic [3:0] {
        ST_BYTE   = 4'd0,
        ST_DONE   = 4'd1,
        ST_UNEXP  = 4'd2,
        ST_ENDQ   = 4'd3,
        ST_CTRL   = 4'd4,
        ST_BADESC = 4'd5,
        ST_BADHEX = 4'd6,
        ST_TRESC  = 4'd7,
        ST_TRUNI  = 4'd8,
        ST_UNTERM = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] value;
        status_t    status;
    } res_item_t;

    typedef struct packed {
        logic [RunCountW-1:0]         count;
        res_item_t [MaxRun-1:0]       item;
    } run_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.valid  = 1'b1;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.nibble = c[3:0] + 4'd9;
        end
        else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
    endfunction

endpackage

// File: rtl/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, decoder and result
// buffer. Uses jsu_pkg, jsu_decode and jsu_run_buf.
//
// Usage: text bytes enter on the in channel (in_valid, in_ready, in_data),
// one beat per byte, with final_byte marking the last byte of the text.
// Decoded string bytes and status codes leave on the out channel
// (out_valid, out_ready, out_data); last_of_run marks the final result
// beat caused by one input byte. A byte may cause no beat at all.
// An accepted byte waits in the input register until the result buffer is
// free, is then decoded combinationally and loaded into the buffer as a run,
// and its first result beat is offered from the buffer register.
// Throughput: one byte per cycle while each byte yields at most one beat
// and out_ready stays high. A unicode escape that encodes to two or three
// UTF-8 bytes, or any run that adds an unterminated status, holds the input
// until its extra beats leave, as the buffer sends one beat per cycle at most.
// Reset clears the decoder to waiting for an opening quote and empties both
// the input register and the result buffer. When the receiver stalls, the
// pending run stays put, one more byte waits in the input register, and
// in_ready drops until the run drains.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic     in_valid_reg;
    in_beat_t in_data_reg;
    logic     free;
    logic     load;
    run_t     run;

    assign load     = in_valid_reg && free;
    assign in_ready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end
        else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_data_reg <= in_data;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (load),
        .beat    (in_data_reg),
        .run     (run)
    );

    jsu_run_buf u_run_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .run       (run),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !load |=> in_valid_reg && $stable(in_data_reg))
        else $error("waiting input byte lost or changed");

endmodule

// File: rtl/jsu_decode.sv
// Decoder for the JSON string unescaper: phase and escape state plus the
// logic that turns one text byte into a run of up to four results. Uses jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_beat_t beat,
    output run_t     run
);

    phase_t      phase_reg,  phase_next;
    logic [11:0] accum_reg,  accum_next;
    logic [1:0]  digits_reg, digits_next;

    logic [7:0]  c;
    logic        fin;
    hex_t        hv;
    logic [15:0] code;

    assign c    = beat.text_byte;
    assign fin  = beat.final_byte;
    assign hv   = hex_value(c);
    assign code = {accum_reg, hv.nibble};

    always_comb
    begin
        run         = '0;
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        case (phase_reg)
            PH_STR:
            begin
                if (c == ChQuote) begin
                    run.item[0] = '{8'd0, ST_DONE};
                    run.count   = RunCountW'(1);
                    phase_next  = PH_WAIT;
                end
                else if (c < ChSpace) begin
                    run.item[0] = '{8'd0, ST_CTRL};
                    run.count   = RunCountW'(1);
                    phase_next  = PH_WAIT;
                end
                else if (c == ChBackslash) begin
                    if (fin) begin
                        run.item[0] = '{8'd0, ST_TRESC};
                        run.count   = RunCountW'(1);
                        phase_next  = PH_WAIT;
                    end
                    else begin
                        phase_next = PH_ESC;
                    end
                end
                else begin
                    run.item[0] = '{c, ST_BYTE};
                    run.count   = RunCountW'(1);
                end
            end
            PH_ESC:
            begin
                run.count  = RunCountW'(1);
                phase_next = PH_STR;
                case (c)
                    ChQuote:     run.item[0] = '{ChQuote, ST_BYTE};
                    ChBackslash: run.item[0] = '{ChBackslash, ST_BYTE};
                    ChSlash:     run.item[0] = '{ChSlash, ST_BYTE};
                    ChLowB:      run.item[0] = '{ChBs, ST_BYTE};
                    ChLowF:      run.item[0] = '{ChFf, ST_BYTE};
                    ChLowN:      run.item[0] = '{ChLf, ST_BYTE};
                    ChLowR:      run.item[0] = '{ChCr, ST_BYTE};
                    ChLowT:      run.item[0] = '{ChTab, ST_BYTE};
                    ChLowU:
                    begin
                        if (fin) begin
                            run.item[0] = '{8'd0, ST_TRUNI};
                            phase_next  = PH_WAIT;
                        end
                        else begin
                            run.count   = '0;
                            accum_next  = '0;
                            digits_next = '0;
                            phase_next  = PH_HEX;
                        end
                    end
                    default:
                    begin
                        run.item[0] = '{8'd0, ST_BADESC};
                        phase_next  = PH_WAIT;
                    end
                endcase
            end
            PH_HEX:
            begin
                if (!hv.valid) begin
                    run.item[0] = '{8'd0, ST_BADHEX};
                    run.count   = RunCountW'(1);
                    phase_next  = PH_WAIT;
                end
                else if (digits_reg == 2'd3) begin
                    if (code[15:7] == '0) begin
                        run.item[0] = '{{1'b0, code[6:0]}, ST_BYTE};
                        run.count   = RunCountW'(1);
                    end
                    else if (code[15:11] == '0) begin
                        run.item[0] = '{Utf8Lead2 | {3'd0, code[10:6]}, ST_BYTE};
                        run.item[1] = '{Utf8Cont | {2'd0, code[5:0]}, ST_BYTE};
                        run.count   = RunCountW'(2);
                    end
                    else begin
                        run.item[0] = '{Utf8Lead3 | {4'd0, code[15:12]}, ST_BYTE};
                        run.item[1] = '{Utf8Cont | {2'd0, code[11:6]}, ST_BYTE};
                        run.item[2] = '{Utf8Cont | {2'd0, code[5:0]}, ST_BYTE};
                        run.count   = RunCountW'(3);
                    end
                    accum_next  = '0;
                    digits_next = '0;
                    phase_next  = PH_STR;
                end
                else begin
                    accum_next  = code[11:0];
                    digits_next = digits_reg + 2'd1;
                    if (fin) begin
                        run.item[0] = '{8'd0, ST_TRUNI};
                        run.count   = RunCountW'(1);
                        phase_next  = PH_WAIT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                if (c == ChQuote) begin
                    phase_next = PH_STR;
                end
                else if (is_space(c)) begin
                    if (fin) begin
                        run.item[0] = '{8'd0, ST_ENDQ};
                        run.count   = RunCountW'(1);
                    end
                end
                else begin
                    run.item[0] = '{8'd0, ST_UNEXP};
                    run.count   = RunCountW'(1);
                end
            end
        endcase

        if (fin && phase_next == PH_STR) begin
            run.item[run.count[1:0]] = '{8'd0, ST_UNTERM};
            run.count  = run.count + RunCountW'(1);
            phase_next = PH_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_WAIT;
            accum_reg  <= '0;
            digits_reg <= '0;
        end
        else if (advance) begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
        end
    end

    // A run only reaches four results when a three-byte code ends the text.
    a_full_run_ends_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && run.count == RunCountW'(MaxRun)
        |-> run.item[MaxRun-1].status == ST_UNTERM)
        else $error("four-result run without unterminated status");

    a_wait_short_run: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_WAIT |-> run.count <= RunCountW'(1))
        else $error("waiting phase produced more than one result");

    a_hex_digits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_ESC && c == ChLowU && !fin
        |=> phase_reg == PH_HEX && digits_reg == 2'd0 && accum_reg == '0)
        else $error("unicode escape entered with stale digit state");

endmodule

// File: rtl/jsu_run_buf.sv
// Result buffer for the JSON string unescaper: holds one decoded run and
// presents it one beat at a time on the output channel. Uses jsu_pkg.
module jsu_run_buf
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  run_t      run,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    res_item_t [MaxRun-1:0] item_reg;
    logic [RunCountW-1:0]   count_reg;
    logic                   take;

    assign out_valid            = (count_reg != '0);
    assign take                 = out_valid && out_ready;
    assign free                 = (count_reg == '0) || (count_reg == RunCountW'(1) && out_ready);
    assign out_data.out_byte    = item_reg[0].value;
    assign out_data.status      = item_reg[0].status;
    assign out_data.last_of_run = (count_reg == RunCountW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else if (load) begin
            count_reg <= run.count;
        end
        else if (take) begin
            count_reg <= count_reg - RunCountW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            item_reg <= run.item;
        end
        else if (take) begin
            item_reg <= {res_item_t'('0), item_reg[MaxRun-1:1]};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RunCountW'(MaxRun))
        else $error("result count out of range");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("run loaded over undelivered results");

endmodule
